// ----- rtl/core/wtosc_pkg.sv -----
// Shared types, constants and the sine table for the wavetable oscillator.
// No dependencies; every other file refers to it by scoped names.
package wtosc_pkg;

  // Table length must be a power of two; phase wraps modulo TABLE_LEN*65536.
  localparam int unsigned TABLE_LEN  = 2048;
  localparam int unsigned IDX_W      = $clog2(TABLE_LEN);
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned PHASE_W    = IDX_W + FRAC_W;
  localparam int unsigned STEP_W     = 26;
  localparam int unsigned LFO_RATE_W = 14;
  localparam int unsigned LFO_SHIFT  = 12;
  localparam int unsigned LFO_OFS_W  = 24;
  localparam int unsigned DEPTH_SHIFT = 8;
  localparam int unsigned VOL_W      = 16;
  localparam int unsigned WAVE_W     = 16;
  localparam int unsigned MIX_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 26;
  localparam logic [VOL_W-1:0] ALIVE_MIN = VOL_W'(64);
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Reciprocals of the Taylor divisors (2k)(2k+1), scaled by 2^64 and rounded up;
  // a multiply and taking the upper half then gives the exact floor quotient.
  localparam logic [127:0] TAYLOR_RECIP [8] = '{
    ((128'd1 << 64) / 128'd6)   + 128'd1,
    ((128'd1 << 64) / 128'd20)  + 128'd1,
    ((128'd1 << 64) / 128'd42)  + 128'd1,
    ((128'd1 << 64) / 128'd72)  + 128'd1,
    ((128'd1 << 64) / 128'd110) + 128'd1,
    ((128'd1 << 64) / 128'd156) + 128'd1,
    ((128'd1 << 64) / 128'd210) + 128'd1,
    ((128'd1 << 64) / 128'd272) + 128'd1
  };

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_CONTROL = 2'd1,
    OP_NOTE_ON = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP     = 3'd0,
    REG_WAVEFORM       = 3'd1,
    REG_MIX_ENABLE     = 3'd2,
    REG_RELEASE_FACTOR = 3'd3,
    REG_LFO_RATE       = 3'd4,
    REG_LFO_DEPTH      = 3'd5,
    REG_START_VOLUME   = 3'd6
  } reg_e;

  typedef struct packed {
    logic [STEP_W-1:0]     phase_step;
    logic                  waveform;
    logic                  mix_enable;
    logic [VOL_W-1:0]      release_factor;
    logic [LFO_RATE_W-1:0] lfo_rate;
    logic [VOL_W-1:0]      lfo_depth;
    logic [VOL_W-1:0]      start_volume;
  } cfg_t;

  typedef logic signed [WAVE_W-1:0] sine_rom_t [TABLE_LEN];

  // One entry: quarter-wave fold, then a Q30 Taylor series, scaled to 32767.
  function automatic logic signed [WAVE_W-1:0] sine_entry(int unsigned i);
    longint unsigned t;
    longint unsigned u;
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    logic            neg;
    logic [127:0]    quot;
    t   = (longint'(i) << 32) >> IDX_W;
    neg = t[31];
    u   = t & 64'h7FFF_FFFF;
    if (u > (64'd1 << 30)) begin
      u = (64'd1 << 31) - u;
    end
    x    = (u * HALF_PI_Q30) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      quot = 128'(term) * TAYLOR_RECIP[k-1];
      term = quot[127:64];
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum * 32767) >>> 30;
    if (sum > 32767) begin
      sum = 32767;
    end
    if (neg) begin
      sum = -sum;
    end
    return WAVE_W'(sum);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int unsigned i = 0; i < TABLE_LEN; i++) begin
      rom[i] = sine_entry(i);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ----- rtl/core/wtosc_intf.sv -----
// Handshake channels of the oscillator: input items, result items, register writes.
// Depends on wtosc_pkg for field widths.
interface wtosc_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        op;
  logic signed [wtosc_pkg::MIX_W-1:0] mix_in;

  modport source (output valid, output op, output mix_in, input ready);
  modport sink   (input valid, input op, input mix_in, output ready);
endinterface

interface wtosc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [wtosc_pkg::MIX_W-1:0] sample_out;
  logic                              alive;

  modport source (output valid, output sample_out, output alive, input ready);
  modport sink   (input valid, input sample_out, input alive, output ready);
endinterface

interface wtosc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [wtosc_pkg::CFG_IDX_W-1:0]     index;
  logic [wtosc_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/wtosc_cfg_regs.sv -----
// Configuration register file of the oscillator.
// Depends on wtosc_pkg and wtosc_cfg_if.
module wtosc_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  wtosc_cfg_if.sink           cfg_i,
  output wtosc_pkg::cfg_t     cfg_o
);

  wtosc_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (wtosc_pkg::reg_e'(cfg_i.index))
        wtosc_pkg::REG_PHASE_STEP:     cfg_q.phase_step <= cfg_i.data[wtosc_pkg::STEP_W-1:0];
        wtosc_pkg::REG_WAVEFORM:       cfg_q.waveform   <= cfg_i.data[0];
        wtosc_pkg::REG_MIX_ENABLE:     cfg_q.mix_enable <= cfg_i.data[0];
        wtosc_pkg::REG_RELEASE_FACTOR: cfg_q.release_factor <= cfg_i.data[wtosc_pkg::VOL_W-1:0];
        wtosc_pkg::REG_LFO_RATE:       cfg_q.lfo_rate <= cfg_i.data[wtosc_pkg::LFO_RATE_W-1:0];
        wtosc_pkg::REG_LFO_DEPTH:      cfg_q.lfo_depth <= cfg_i.data[wtosc_pkg::VOL_W-1:0];
        wtosc_pkg::REG_START_VOLUME:   cfg_q.start_volume <= cfg_i.data[wtosc_pkg::VOL_W-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

endmodule

// ----- rtl/core/wtosc_sine_rom.sv -----
// Sine table as a synchronous ROM with one registered read port.
// Depends on wtosc_pkg for the table contents.
module wtosc_sine_rom (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [wtosc_pkg::IDX_W-1:0]         addr_i,
  output logic signed [wtosc_pkg::WAVE_W-1:0] data_o
);

  logic signed [wtosc_pkg::WAVE_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= wtosc_pkg::SINE_ROM[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// ----- rtl/core/wavetable_oscillator_with_lfo.sv -----
// Wavetable oscillator with LFO: top level with the three-stage item pipeline.
// Depends on wtosc_pkg, the channel interfaces, wtosc_cfg_regs and wtosc_sine_rom.
//
// The block takes one item per clock cycle while not stalled or held off and
// returns one result item for each; the result passes stage 1, stage 2 and the
// output register and can leave when the output is not stalled. The phase,
// LFO phase and volume are updated in the cycle an item is accepted, and that
// same cycle issues the read of the sine ROM, whose data is registered. The
// LFO offset that the next sample tick adds to the phase comes from that ROM
// read times lfo_depth, so the input holds ready low while a control tick
// sits in stage 1, which it leaves only when the output is not stalled; every
// other sequence of items runs at one item per cycle while the output is not
// stalled. A stalled output stalls all three stages together, and an item can
// be accepted in the same cycle as the waiting result is taken. Configuration
// is written through its own channel, which is always ready.
module wavetable_oscillator_with_lfo (
  input  logic           clk_i,
  input  logic           rst_ni,
  wtosc_cfg_if.sink      cfg_i,
  wtosc_in_if.sink       in_i,
  wtosc_out_if.source    out_o
);

  localparam int unsigned PW = wtosc_pkg::PHASE_W;
  localparam int unsigned VW = wtosc_pkg::VOL_W;
  localparam int unsigned WW = wtosc_pkg::WAVE_W;
  localparam int unsigned MW = wtosc_pkg::MIX_W;
  localparam int unsigned PRODW = VW + WW + 1;

  wtosc_pkg::cfg_t cfg;

  wtosc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Architectural state.
  logic [PW-1:0]                          phase_q, phase_d;
  logic [PW-1:0]                          lfo_phase_q, lfo_phase_d;
  logic signed [wtosc_pkg::LFO_OFS_W-1:0] lfo_offset_q;
  logic [VW-1:0]                          volume_q, volume_d;

  // Pipeline registers.
  logic                  s1_valid_q;
  wtosc_pkg::op_e        s1_op_q;
  logic                  s1_alive_q;
  logic [VW-1:0]         s1_vol_q;
  logic signed [WW-1:0]  s1_saw_q;
  logic signed [MW-1:0]  s1_mix_q;

  logic                  s2_valid_q;
  logic                  s2_is_sample_q;
  logic                  s2_alive_q;
  logic signed [PRODW-1:0] s2_prod_q;
  logic signed [MW-1:0]  s2_mix_q;

  logic                  out_valid_q;
  logic signed [MW-1:0]  out_sample_q;
  logic                  out_alive_q;

  logic                  advance;
  logic                  accept;
  logic                  is_sample;
  logic [2*VW-1:0]       decay_prod;
  logic [wtosc_pkg::IDX_W-1:0] rom_addr;
  logic signed [WW-1:0]  rom_data;
  logic signed [WW-1:0]  saw_d;

  // Advance all stages when the output slot is free or being emptied.
  assign advance = !out_valid_q || out_o.ready;
  // Hold off while a control tick still has its LFO offset in flight.
  assign in_i.ready = advance && !(s1_valid_q && (s1_op_q == wtosc_pkg::OP_CONTROL));
  assign accept     = in_i.valid && in_i.ready;
  assign is_sample  = (in_i.op == wtosc_pkg::OP_SAMPLE);

  // Phase wraps modulo a power of two: keep the low bits of the sum.
  assign phase_d = phase_q + PW'(cfg.phase_step) + PW'(lfo_offset_q);
  assign lfo_phase_d = lfo_phase_q + PW'({cfg.lfo_rate, {wtosc_pkg::LFO_SHIFT{1'b0}}});
  assign decay_prod  = volume_q * cfg.release_factor;

  always_comb begin
    volume_d = volume_q;
    unique case (wtosc_pkg::op_e'(in_i.op))
      wtosc_pkg::OP_CONTROL: begin
        if ((cfg.release_factor != '0) && (volume_q > wtosc_pkg::ALIVE_MIN)) begin
          volume_d = decay_prod[2*VW-1:VW];
        end
      end
      wtosc_pkg::OP_NOTE_ON: volume_d = cfg.start_volume;
      wtosc_pkg::OP_SAMPLE:  volume_d = volume_q;
      default:               volume_d = volume_q; // unused code: leave state alone
    endcase
  end

  // Sawtooth: top 16 phase bits minus half scale, i.e. top bit inverted.
  assign saw_d    = {~phase_d[PW-1], phase_d[PW-2:wtosc_pkg::IDX_W]};
  assign rom_addr = is_sample ? phase_d[PW-1:wtosc_pkg::FRAC_W]
                              : lfo_phase_d[PW-1:wtosc_pkg::FRAC_W];

  wtosc_sine_rom u_sine_rom (
    .clk_i  (clk_i),
    .en_i   (accept),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // State update at acceptance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      lfo_phase_q <= '0;
      volume_q    <= '0;
    end else if (accept) begin
      volume_q <= volume_d;
      if (is_sample) begin
        phase_q <= phase_d;
      end
      if (in_i.op == wtosc_pkg::OP_CONTROL) begin
        lfo_phase_q <= lfo_phase_d;
      end
    end
  end

  // Stage 1: ROM data is back; pick the waveform and scale by volume.
  logic signed [WW-1:0]    wave_s1;
  logic signed [PRODW-1:0] smp_prod;
  logic signed [PRODW-1:0] lfo_prod;

  assign wave_s1  = cfg.waveform ? s1_saw_q : rom_data;
  assign smp_prod = $signed({1'b0, s1_vol_q}) * wave_s1;
  assign lfo_prod = $signed({1'b0, cfg.lfo_depth}) * rom_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfo_offset_q <= '0;
    end else if (advance && s1_valid_q && (s1_op_q == wtosc_pkg::OP_CONTROL)) begin
      // Floor shift by eight; the result always fits the offset width.
      lfo_offset_q <= lfo_prod[wtosc_pkg::DEPTH_SHIFT +: wtosc_pkg::LFO_OFS_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_op_q     <= wtosc_pkg::OP_SAMPLE;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= accept;
      s1_op_q     <= wtosc_pkg::op_e'(in_i.op);
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // Payload of the stages: no reset needed.
  logic signed [PRODW-wtosc_pkg::FRAC_W-1:0] scaled;
  logic signed [MW:0]    mix_sum;
  logic signed [MW-1:0]  sample_d;

  assign scaled  = s2_prod_q[PRODW-1:wtosc_pkg::FRAC_W];
  assign mix_sum = (MW+1)'(scaled) + (MW+1)'(s2_mix_q);

  always_comb begin
    sample_d = '0;
    if (s2_is_sample_q) begin
      if (!cfg.mix_enable) begin
        sample_d = MW'(scaled);
      end else if (mix_sum[MW] != mix_sum[MW-1]) begin
        // Saturate on overflow towards the sign of the true sum.
        sample_d = mix_sum[MW] ? {1'b1, {(MW-1){1'b0}}} : {1'b0, {(MW-1){1'b1}}};
      end else begin
        sample_d = mix_sum[MW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_alive_q     <= (volume_d > wtosc_pkg::ALIVE_MIN);
      s1_vol_q       <= volume_q;
      s1_saw_q       <= saw_d;
      s1_mix_q       <= in_i.mix_in;
      s2_is_sample_q <= (s1_op_q == wtosc_pkg::OP_SAMPLE);
      s2_alive_q     <= s1_alive_q;
      s2_prod_q      <= smp_prod;
      s2_mix_q       <= s1_mix_q;
      out_sample_q   <= sample_d;
      out_alive_q    <= s2_alive_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_sample_q;
  assign out_o.alive      = out_alive_q;

endmodule

// ----- tb/sv/wavetable_oscillator_with_lfo_tb.sv -----
// Self-checking testbench for the wavetable oscillator with LFO.
// Depends on wtosc_pkg, the channel interfaces and the oscillator top level;
// predicts every result item in-bench and compares it as it leaves the block.
module wavetable_oscillator_with_lfo_tb;

  // Predictor geometry: table length and the span of the phase accumulator.
  localparam longint SINE_LEN = 2048;
  localparam longint ACC_SPAN = SINE_LEN * 65536;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic signed [wtosc_pkg::MIX_W-1:0] MIX_TOP = 32'sh7FFF_FFFF;
  localparam logic signed [wtosc_pkg::MIX_W-1:0] MIX_BOTTOM = 32'sh8000_0000;

  typedef struct {
    logic [1:0]                         op;
    logic signed [wtosc_pkg::MIX_W-1:0] mix_in;
  } osc_item_t;

  typedef struct {
    logic signed [wtosc_pkg::MIX_W-1:0] sample;
    logic                               alive;
  } osc_result_t;

  logic clk_i;
  logic rst_ni;

  wtosc_cfg_if cfg_if ();
  wtosc_in_if  in_if ();
  wtosc_out_if out_if ();

  wavetable_oscillator_with_lfo i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Items waiting for the driver, and the results still owed by the block.
  osc_item_t   pending_items[$];
  osc_result_t awaited_results[$];
  osc_item_t   next_item;
  osc_result_t got_result;
  osc_result_t want_result;

  int  mismatches;
  int  accepted_count;
  logic item_accepted;
  logic steady;
  int  hold_left;
  logic hold_done;

  // Predictor copy of the sine table, the oscillator state and the registers.
  logic signed [15:0] sine_tab [SINE_LEN];
  logic [26:0]        acc_phase;
  logic [26:0]        lfo_acc;
  logic signed [23:0] lfo_ofs;
  logic [15:0]        env_level;
  logic [25:0]        step_reg;
  logic               saw_reg;
  logic               mix_reg;
  logic [15:0]        release_reg;
  logic [13:0]        lrate_reg;
  logic [15:0]        depth_reg;
  logic [15:0]        start_reg;

  // Hold both sides busy for a stretch so that back-to-back traffic is seen too.
  assign steady = (accepted_count >= 300) && (accepted_count < 420);

  // Sine level for table entry n: fold into the first quarter, run a Q30
  // Taylor series of eight terms past x, scale to 32767 and floor.
  function automatic logic signed [15:0] sine_level(int unsigned n);
    longint unsigned turn;
    longint unsigned fold;
    longint unsigned arg;
    longint unsigned term;
    longint          acc;
    logic            lower_half;
    turn = n;
    turn = (turn << 32) / SINE_LEN;
    lower_half = turn[31];
    fold = turn & 64'h7FFF_FFFF;
    if (fold > (64'd1 << 30)) begin
      fold = (64'd1 << 31) - fold;
    end
    arg  = (fold * 64'd1686629713) >> 30;
    term = arg;
    acc  = arg;
    for (int k = 1; k <= 8; k++) begin
      term = (((term * arg) >> 30) * arg) >> 30;
      term = term / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc * 32767) >>> 30;
    if (acc > 32767) begin
      acc = 32767;
    end
    return lower_half ? 16'(-acc) : 16'(acc);
  endfunction

  // Bring an accumulator back into [0, ACC_SPAN): one correction, then a full
  // reduction should that not be enough.
  function automatic longint wrap_acc(longint p);
    if (p >= ACC_SPAN) begin
      p = p - ACC_SPAN;
    end else if (p < 0) begin
      p = p + ACC_SPAN;
    end
    if (p >= ACC_SPAN || p < 0) begin
      p = p % ACC_SPAN;
      if (p < 0) begin
        p = p + ACC_SPAN;
      end
    end
    return p;
  endfunction

  // Advance the predicted oscillator by one item and form its result.
  task automatic synth_step(input logic [1:0] op,
                            input logic signed [wtosc_pkg::MIX_W-1:0] mix,
                            output osc_result_t res);
    longint wv;
    longint s;
    s = 0;
    case (op)
      wtosc_pkg::OP_SAMPLE: begin
        acc_phase = 27'(wrap_acc(longint'(acc_phase) + longint'(step_reg)
                                 + longint'(lfo_ofs)));
        if (saw_reg) begin
          wv = longint'(acc_phase >> 11) - 32768;
        end else begin
          wv = sine_tab[acc_phase[26:16]];
        end
        // Arithmetic shift floors negative products.
        s = (longint'(env_level) * wv) >>> 16;
        if (mix_reg) begin
          s = s + longint'(mix);
          if (s > 64'sd2147483647) begin
            s = 64'sd2147483647;
          end
          if (s < -64'sd2147483648) begin
            s = -64'sd2147483648;
          end
        end
      end
      wtosc_pkg::OP_CONTROL: begin
        if (release_reg != 0 && env_level > 64) begin
          env_level = 16'((longint'(env_level) * longint'(release_reg)) >> 16);
        end
        lfo_acc = 27'(wrap_acc(longint'(lfo_acc) + (longint'(lrate_reg) << 12)));
        lfo_ofs = 24'((longint'(depth_reg) * longint'(sine_tab[lfo_acc[26:16]])) >>> 8);
      end
      wtosc_pkg::OP_NOTE_ON: begin
        env_level = start_reg;
      end
      default: begin
        // Spare op code: leave every piece of state alone.
      end
    endcase
    res.sample = s[31:0];
    res.alive  = (env_level > 64);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Sender: offer the next queued item once the current one has been taken,
  // idling at random unless the steady stretch is on.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || item_accepted) begin
      if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 34)) begin
        next_item = pending_items.pop_front();
        in_if.valid  <= 1'b1;
        in_if.op     <= next_item.op;
        in_if.mix_in <= next_item.mix_in;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random, and once hold off long enough for the block
  // to fill up and push back on its input.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && accepted_count >= 600) begin
      hold_done    <= 1'b1;
      hold_left    <= 150;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= steady || ($urandom_range(99) >= 34);
    end
  end

  // Monitor: track register writes, check each result item against the oldest
  // prediction, and predict each accepted input item.
  always @(posedge clk_i) begin
    item_accepted <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          wtosc_pkg::REG_PHASE_STEP:     step_reg    = cfg_if.data[25:0];
          wtosc_pkg::REG_WAVEFORM:       saw_reg     = cfg_if.data[0];
          wtosc_pkg::REG_MIX_ENABLE:     mix_reg     = cfg_if.data[0];
          wtosc_pkg::REG_RELEASE_FACTOR: release_reg = cfg_if.data[15:0];
          wtosc_pkg::REG_LFO_RATE:       lrate_reg   = cfg_if.data[13:0];
          wtosc_pkg::REG_LFO_DEPTH:      depth_reg   = cfg_if.data[15:0];
          wtosc_pkg::REG_START_VOLUME:   start_reg   = cfg_if.data[15:0];
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result item, sample_out %0d alive %0b", $time,
                   out_if.sample_out, out_if.alive);
        end else begin
          want_result = awaited_results.pop_front();
          if (out_if.sample_out !== want_result.sample) begin
            mismatches++;
            $display("%0t: sample_out expected %0d actual %0d", $time,
                     want_result.sample, out_if.sample_out);
          end
          if (out_if.alive !== want_result.alive) begin
            mismatches++;
            $display("%0t: alive expected %0b actual %0b", $time,
                     want_result.alive, out_if.alive);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        accepted_count++;
        synth_step(in_if.op, in_if.mix_in, got_result);
        awaited_results.push_back(got_result);
      end
    end
  end

  task automatic queue_item(input logic [1:0] op,
                            input logic signed [wtosc_pkg::MIX_W-1:0] mix);
    osc_item_t it;
    it.op     = op;
    it.mix_in = mix;
    pending_items.push_back(it);
  endtask

  task automatic write_reg(input wtosc_pkg::reg_e idx,
                           input logic [wtosc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic write_setup(input logic [25:0] step, input logic saw, input logic mix,
                             input logic [15:0] rel, input logic [13:0] lrate,
                             input logic [15:0] depth, input logic [15:0] start);
    write_reg(wtosc_pkg::REG_PHASE_STEP, step);
    write_reg(wtosc_pkg::REG_WAVEFORM, wtosc_pkg::CFG_DATA_W'(saw));
    write_reg(wtosc_pkg::REG_MIX_ENABLE, wtosc_pkg::CFG_DATA_W'(mix));
    write_reg(wtosc_pkg::REG_RELEASE_FACTOR, wtosc_pkg::CFG_DATA_W'(rel));
    write_reg(wtosc_pkg::REG_LFO_RATE, wtosc_pkg::CFG_DATA_W'(lrate));
    write_reg(wtosc_pkg::REG_LFO_DEPTH, wtosc_pkg::CFG_DATA_W'(depth));
    write_reg(wtosc_pkg::REG_START_VOLUME, wtosc_pkg::CFG_DATA_W'(start));
  endtask

  // Wait until every queued item has gone in and every result has come out,
  // then let the pipeline settle before the registers are touched again.
  task automatic drain();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_if.valid || awaited_results.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    int unsigned pick;
    logic signed [wtosc_pkg::MIX_W-1:0] mix;
    for (int n = 0; n < SINE_LEN; n++) begin
      sine_tab[n] = sine_level(n);
    end
    acc_phase = '0;
    lfo_acc   = '0;
    lfo_ofs   = '0;
    env_level = '0;
    step_reg  = '0;
    saw_reg   = 1'b0;
    mix_reg   = 1'b0;
    release_reg = '0;
    lrate_reg = '0;
    depth_reg = '0;
    start_reg = '0;
    mismatches = 0;
    accepted_count = 0;
    item_accepted = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    in_if.valid  = 1'b0;
    in_if.op     = wtosc_pkg::OP_SAMPLE;
    in_if.mix_in = '0;
    out_if.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Registers at their reset values: every op once, silence expected.
    queue_item(wtosc_pkg::OP_SAMPLE, 32'sd12345);
    queue_item(wtosc_pkg::OP_CONTROL, -32'sd1);
    queue_item(wtosc_pkg::OP_NOTE_ON, MIX_TOP);
    queue_item(OP_SPARE, MIX_BOTTOM);
    queue_item(wtosc_pkg::OP_SAMPLE, '0);
    drain();

    // Everything but the release factor at full scale, sawtooth into the mixer:
    // drive both saturation limits and the extremes of mix_in.
    write_setup(26'h3FF_FFFF, 1'b1, 1'b1, 16'd0, 14'h3FFF, 16'hFFFF, 16'hFFFF);
    queue_item(wtosc_pkg::OP_NOTE_ON, '0);
    queue_item(wtosc_pkg::OP_SAMPLE, MIX_BOTTOM);
    queue_item(wtosc_pkg::OP_SAMPLE, MIX_TOP);
    queue_item(wtosc_pkg::OP_SAMPLE, '0);
    queue_item(wtosc_pkg::OP_SAMPLE, -32'sd1);
    queue_item(wtosc_pkg::OP_CONTROL, '0);
    queue_item(wtosc_pkg::OP_SAMPLE, MIX_TOP);
    queue_item(wtosc_pkg::OP_CONTROL, MIX_BOTTOM);
    queue_item(wtosc_pkg::OP_SAMPLE, MIX_BOTTOM);
    queue_item(OP_SPARE, MIX_TOP);
    queue_item(wtosc_pkg::OP_SAMPLE, 32'sd1);
    drain();

    // Zero step, sine, fast release and a deep LFO: the offset goes negative,
    // so the phase wraps downward, and the volume decays until not alive.
    write_setup(26'd0, 1'b0, 1'b0, 16'd20000, 14'h3FFF, 16'hFFFF, 16'hFFFF);
    queue_item(wtosc_pkg::OP_NOTE_ON, '0);
    for (int n = 0; n < 8; n++) begin
      queue_item(wtosc_pkg::OP_CONTROL, 32'(n));
      queue_item(wtosc_pkg::OP_SAMPLE, 32'($urandom));
    end
    queue_item(wtosc_pkg::OP_NOTE_ON, '0);
    queue_item(wtosc_pkg::OP_SAMPLE, '0);
    drain();

    // Random part: eight settings, the two extremes first, then random ones.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        write_setup(26'h3FF_FFFF, 1'b0, 1'b1, 16'hFFFF, 14'h3FFF, 16'hFFFF, 16'hFFFF);
      end else if (ph == 1) begin
        write_setup(26'd0, 1'b1, 1'b0, 16'd0, 14'd0, 16'd0, 16'd0);
      end else begin
        write_setup(($urandom_range(1) != 0) ? 26'($urandom) : 26'($urandom_range(1 << 20)),
                    1'($urandom), 1'($urandom),
                    ($urandom_range(1) != 0) ? 16'($urandom_range(65535, 50000))
                                             : 16'($urandom),
                    14'($urandom), 16'($urandom), 16'($urandom));
      end
      for (int n = 0; n < 100; n++) begin
        pick = $urandom_range(99);
        mix  = 32'($urandom);
        if ($urandom_range(9) == 0) begin
          mix = ($urandom_range(1) != 0) ? MIX_TOP : MIX_BOTTOM;
        end
        if (pick < 60) begin
          queue_item(wtosc_pkg::OP_SAMPLE, mix);
        end else if (pick < 80) begin
          queue_item(wtosc_pkg::OP_CONTROL, mix);
        end else if (pick < 92) begin
          queue_item(wtosc_pkg::OP_NOTE_ON, mix);
        end else begin
          queue_item(OP_SPARE, mix);
        end
      end
      drain();
    end

    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

endmodule
